// ----- hdl/blpd_pkg.sv -----
// ----------------------------------------------------------------------------
// blpd_pkg
// Types and constants for the block luma predictive decoder.
// ----------------------------------------------------------------------------
package blpd_pkg;

  localparam int unsigned LumaW   = 6;
  localparam int unsigned HeaderW = 14;
  localparam int unsigned PosW    = 4;
  localparam int unsigned SumW    = 10;
  localparam int unsigned CoordW  = 2;
  localparam int unsigned RowLen  = 4;

  typedef logic [LumaW-1:0] luma_t;

  typedef enum logic [1:0] {
    CMD_FRAME_START = 2'd0,
    CMD_HEADER      = 2'd1,
    CMD_RESIDUAL    = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_e;

  // Header opcode expected for each block size
  localparam logic [1:0] OPC_LARGE = 2'd1;
  localparam logic [1:0] OPC_SMALL = 2'd2;

  // Last pixel position of each block size
  localparam logic [PosW-1:0] LAST_POS_LARGE = 4'd15;
  localparam logic [PosW-1:0] LAST_POS_SMALL = 4'd3;

endpackage

// ----- hdl/block_luma_predictive_decoder_top.sv -----
// ----------------------------------------------------------------------------
// block_luma_predictive_decoder_top
// Rebuilds 6-bit luma of 4x4 / 2x2 blocks from decoded residual symbols.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one command item: frame
//   start (loads the luma predictor), block header (opcode, U, V) or one
//   luma residual. Output channel (out_valid_o / out_ready_i) gives one
//   item per residual inside an open block, and one error item for a
//   header whose opcode does not match the block size. Other items give
//   no output.
//   An accepted item lands in an input register; it moves on through
//   prediction (add and average) into the result register once that
//   register is empty or out_ready_i is high. One item per cycle is
//   sustained while out_ready_i stays high; the input register lets one
//   more item in while a result waits.
//   Reset clears the predictor, chroma and block state and both valid
//   flags. When the receiver stalls, the result register holds, the input
//   register fills, and in_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
module block_luma_predictive_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic        block_large_i,
  input  logic [13:0] header_word_i,
  input  logic [5:0]  residual_i,
  input  logic [5:0]  start_luma_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  luma_o,
  output logic [5:0]  chroma_u_o,
  output logic [5:0]  chroma_v_o,
  output logic [1:0]  pixel_row_o,
  output logic [1:0]  pixel_column_o,
  output logic        block_done_o,
  output logic        opcode_error_o
);

  // Input register
  logic                                in_valid_q;
  logic [1:0]                          cmd_q;
  logic                                large_q;
  logic [blpd_pkg::HeaderW-1:0]        header_q;
  blpd_pkg::luma_t                     residual_q;
  blpd_pkg::luma_t                     start_q;

  // Decoder state
  blpd_pkg::luma_t                     pred_q, pred_d;
  blpd_pkg::luma_t                     u_q, u_d;
  blpd_pkg::luma_t                     v_q, v_d;
  logic                                size_large_q, size_large_d;
  logic                                active_q, active_d;
  logic [blpd_pkg::PosW-1:0]           pos_q, pos_d;
  logic [blpd_pkg::SumW-1:0]           sum_q, sum_d;
  blpd_pkg::luma_t                     row_above_q [blpd_pkg::RowLen];
  blpd_pkg::luma_t                     left_q;

  // Result register
  logic                                out_valid_q, out_valid_d;
  blpd_pkg::luma_t                     luma_q, luma_d;
  blpd_pkg::luma_t                     res_u_q, res_u_d;
  blpd_pkg::luma_t                     res_v_q, res_v_d;
  logic [blpd_pkg::CoordW-1:0]         row_q, row_d;
  logic [blpd_pkg::CoordW-1:0]         col_q, col_d;
  logic                                done_q, done_d;
  logic                                err_q, err_d;

  logic                                advance;
  logic                                has_result;
  logic                                pix_en;
  logic [blpd_pkg::CoordW-1:0]         row_c, col_c;
  blpd_pkg::luma_t                     above_c, pred_c, y_c;
  logic [blpd_pkg::LumaW:0]            avg_sum;
  logic                                last_c;
  logic [1:0]                          opc_expect;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q      <= command_i;
      large_q    <= block_large_i;
      header_q   <= header_word_i;
      residual_q <= residual_i;
      start_q    <= start_luma_i;
    end
  end

  // Pixel coordinates from the running position
  always_comb begin
    if (size_large_q) begin
      row_c  = pos_q[3:2];
      col_c  = pos_q[1:0];
      last_c = (pos_q == blpd_pkg::LAST_POS_LARGE);
    end else begin
      row_c  = {1'b0, pos_q[1]};
      col_c  = {1'b0, pos_q[0]};
      last_c = (pos_q == blpd_pkg::LAST_POS_SMALL);
    end
  end

  assign above_c = row_above_q[col_c];
  assign avg_sum = {1'b0, left_q} + {1'b0, above_c};

  always_comb begin
    if (row_c == '0) begin
      pred_c = (col_c == '0) ? pred_q : left_q;
    end else if (col_c == '0) begin
      pred_c = above_c;
    end else begin
      pred_c = avg_sum[blpd_pkg::LumaW:1];
    end
  end

  assign y_c        = pred_c + residual_q;  // wraps mod 64
  assign opc_expect = large_q ? blpd_pkg::OPC_LARGE : blpd_pkg::OPC_SMALL;

  always_comb begin
    pred_d       = pred_q;
    u_d          = u_q;
    v_d          = v_q;
    size_large_d = size_large_q;
    active_d     = active_q;
    pos_d        = pos_q;
    sum_d        = sum_q;
    has_result   = 1'b0;
    pix_en       = 1'b0;
    luma_d       = '0;
    res_u_d      = '0;
    res_v_d      = '0;
    row_d        = '0;
    col_d        = '0;
    done_d       = 1'b0;
    err_d        = 1'b0;

    case (blpd_pkg::cmd_e'(cmd_q))
      blpd_pkg::CMD_FRAME_START: begin
        pred_d   = start_q;
        active_d = 1'b0;
      end
      blpd_pkg::CMD_HEADER: begin
        if (header_q[1:0] != opc_expect) begin
          active_d   = 1'b0;
          has_result = 1'b1;
          err_d      = 1'b1;
        end else begin
          u_d          = header_q[7:2];
          v_d          = header_q[13:8];
          size_large_d = large_q;
          active_d     = 1'b1;
          pos_d        = '0;
          sum_d        = '0;
        end
      end
      blpd_pkg::CMD_RESIDUAL: begin
        if (active_q) begin
          pix_en     = 1'b1;
          has_result = 1'b1;
          sum_d      = sum_q + {{(blpd_pkg::SumW-blpd_pkg::LumaW){1'b0}}, y_c};
          if (last_c) begin
            // block mean becomes the next predictor
            pred_d   = size_large_q ? sum_d[9:4] : sum_d[7:2];
            active_d = 1'b0;
            pos_d    = '0;
          end else begin
            pos_d = pos_q + {{(blpd_pkg::PosW-1){1'b0}}, 1'b1};
          end
          luma_d  = y_c;
          res_u_d = u_q;
          res_v_d = v_q;
          row_d   = row_c;
          col_d   = col_c;
          done_d  = last_c;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q       <= '0;
      u_q          <= '0;
      v_q          <= '0;
      size_large_q <= 1'b0;
      active_q     <= 1'b0;
      pos_q        <= '0;
      sum_q        <= '0;
    end else if (advance) begin
      pred_q       <= pred_d;
      u_q          <= u_d;
      v_q          <= v_d;
      size_large_q <= size_large_d;
      active_q     <= active_d;
      pos_q        <= pos_d;
      sum_q        <= sum_d;
    end
  end

  // Neighbor storage, always written before read within a block
  always_ff @(posedge clk_i) begin
    if (advance && pix_en) begin
      row_above_q[col_c] <= y_c;
      left_q             <= y_c;
    end
  end

  always_comb begin
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      luma_q  <= luma_d;
      res_u_q <= res_u_d;
      res_v_q <= res_v_d;
      row_q   <= row_d;
      col_q   <= col_d;
      done_q  <= done_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign luma_o         = luma_q;
  assign chroma_u_o     = res_u_q;
  assign chroma_v_o     = res_v_q;
  assign pixel_row_o    = row_q;
  assign pixel_column_o = col_q;
  assign block_done_o   = done_q;
  assign opcode_error_o = err_q;

endmodule

// ----- test/block_luma_predictive_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_luma_predictive_decoder_top_tb
// Self-checking bench for the block luma predictive decoder. Frame starts,
// good and bad headers, full and cut-short 2x2 / 4x4 pixel runs, stray
// residuals and unused commands go in under random sender bursts and
// receiver stalls. A scoreboard tracks the predictor, chroma and block
// position, and checks each output item field by field, in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [5:0] luma;
  logic [5:0] chroma_u;
  logic [5:0] chroma_v;
  logic [1:0] pixel_row;
  logic [1:0] pixel_column;
  logic       block_done;
  logic       opcode_error;
} pixel_t;

class luma_scoreboard;
  pixel_t      expected_pixels[$];
  int unsigned error_count;

  blpd_pkg::luma_t predictor;
  blpd_pkg::luma_t chroma_u;
  blpd_pkg::luma_t chroma_v;
  logic            is_large;
  logic            in_block;
  logic [3:0]      position;
  blpd_pkg::luma_t above[4];
  blpd_pkg::luma_t left;
  logic [9:0]      luma_total;

  function new();
    error_count = 0;
    predictor   = '0;
    chroma_u    = '0;
    chroma_v    = '0;
    is_large    = 1'b0;
    in_block    = 1'b0;
    position    = '0;
    luma_total  = '0;
    left        = '0;
    foreach (above[i]) above[i] = '0;
  endfunction

  // Track one accepted item; returns 0 when the block just ignores it.
  function bit note_item(blpd_pkg::cmd_e cmd, logic big, logic [13:0] hdr,
                         blpd_pkg::luma_t res, blpd_pkg::luma_t start);
    pixel_t          pix;
    logic [1:0]      want_opc;
    logic [1:0]      row;
    logic [1:0]      col;
    logic [3:0]      last_pos;
    logic [6:0]      pair;
    blpd_pkg::luma_t pred;
    blpd_pkg::luma_t y;
    pix = '0;
    case (cmd)
      blpd_pkg::CMD_FRAME_START: begin
        predictor = start;
        in_block  = 1'b0;
        return 1'b1;
      end
      blpd_pkg::CMD_HEADER: begin
        want_opc = big ? blpd_pkg::OPC_LARGE : blpd_pkg::OPC_SMALL;
        if (hdr[1:0] != want_opc) begin
          in_block = 1'b0;
          pix.opcode_error = 1'b1;
          expected_pixels.push_back(pix);
          return 1'b1;
        end
        chroma_u   = hdr[7:2];
        chroma_v   = hdr[13:8];
        is_large   = big;
        in_block   = 1'b1;
        position   = '0;
        luma_total = '0;
        return 1'b1;
      end
      blpd_pkg::CMD_RESIDUAL: begin
        if (!in_block) return 1'b0;
        if (is_large) begin
          row      = position[3:2];
          col      = position[1:0];
          last_pos = blpd_pkg::LAST_POS_LARGE;
        end else begin
          row      = {1'b0, position[1]};
          col      = {1'b0, position[0]};
          last_pos = blpd_pkg::LAST_POS_SMALL;
        end
        if (row == 2'd0) begin
          pred = (col == 2'd0) ? predictor : left;
        end else if (col == 2'd0) begin
          pred = above[col];
        end else begin
          pair = {1'b0, left} + {1'b0, above[col]};
          pred = pair[6:1];
        end
        y          = pred + res;
        above[col] = y;
        left       = y;
        luma_total = luma_total + {4'd0, y};
        pix.luma         = y;
        pix.chroma_u     = chroma_u;
        pix.chroma_v     = chroma_v;
        pix.pixel_row    = row;
        pix.pixel_column = col;
        pix.block_done   = (position == last_pos);
        if (pix.block_done) begin
          // block mean becomes the next block's starting prediction
          predictor = is_large ? luma_total[9:4] : luma_total[7:2];
          in_block  = 1'b0;
          position  = '0;
        end else begin
          position = position + 4'd1;
        end
        expected_pixels.push_back(pix);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task check_pixel(pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("output item with nothing pending", 1, 0);
      return;
    end
    want = expected_pixels.pop_front();
    if (got.luma !== want.luma)
      report_mismatch("luma", got.luma, want.luma);
    if (got.chroma_u !== want.chroma_u)
      report_mismatch("chroma_u", got.chroma_u, want.chroma_u);
    if (got.chroma_v !== want.chroma_v)
      report_mismatch("chroma_v", got.chroma_v, want.chroma_v);
    if (got.pixel_row !== want.pixel_row)
      report_mismatch("pixel_row", got.pixel_row, want.pixel_row);
    if (got.pixel_column !== want.pixel_column)
      report_mismatch("pixel_column", got.pixel_column, want.pixel_column);
    if (got.block_done !== want.block_done)
      report_mismatch("block_done", got.block_done, want.block_done);
    if (got.opcode_error !== want.opcode_error)
      report_mismatch("opcode_error", got.opcode_error, want.opcode_error);
  endtask
endclass

module block_luma_predictive_decoder_top_tb;

  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned IdleLimit  = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic        block_large_i;
  logic [13:0] header_word_i;
  logic [5:0]  residual_i;
  logic [5:0]  start_luma_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [5:0]  luma_o;
  logic [5:0]  chroma_u_o;
  logic [5:0]  chroma_v_o;
  logic [1:0]  pixel_row_o;
  logic [1:0]  pixel_column_o;
  logic        block_done_o;
  logic        opcode_error_o;

  luma_scoreboard pixel_board;
  int unsigned    live_items;
  int unsigned    burst_left;
  int unsigned    ready_mode;
  int unsigned    mode_left;
  int unsigned    stall_phase;

  block_luma_predictive_decoder_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .block_large_i  (block_large_i),
    .header_word_i  (header_word_i),
    .residual_i     (residual_i),
    .start_luma_i   (start_luma_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .luma_o         (luma_o),
    .chroma_u_o     (chroma_u_o),
    .chroma_v_o     (chroma_v_o),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .block_done_o   (block_done_o),
    .opcode_error_o (opcode_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic blpd_pkg::luma_t pick_residual();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return blpd_pkg::luma_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_burst();
    // now and then a long stretch with no gaps at all
    if ($urandom_range(0, 9) == 0) return $urandom_range(60, 200);
    return $urandom_range(1, 24);
  endfunction

  task automatic send_item(input blpd_pkg::cmd_e cmd, input logic big,
                           input logic [13:0] hdr, input blpd_pkg::luma_t res,
                           input blpd_pkg::luma_t start);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    block_large_i <= big;
    header_word_i <= hdr;
    residual_i    <= res;
    start_luma_i  <= start;
    do @(posedge clk_i); while (!in_ready_o);
    if (pixel_board.note_item(cmd, big, hdr, res, start)) live_items++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = pick_burst();
    end
  endtask

  // Unused payload fields carry random values throughout.
  task automatic send_frame_start(input blpd_pkg::luma_t start);
    send_item(blpd_pkg::CMD_FRAME_START, 1'($urandom), 14'($urandom),
              blpd_pkg::luma_t'($urandom), start);
  endtask

  task automatic send_header(input logic big, input logic [1:0] opc,
                             input blpd_pkg::luma_t u, input blpd_pkg::luma_t v);
    send_item(blpd_pkg::CMD_HEADER, big, {v, u, opc}, blpd_pkg::luma_t'($urandom),
              blpd_pkg::luma_t'($urandom));
  endtask

  task automatic send_residual(input blpd_pkg::luma_t res);
    send_item(blpd_pkg::CMD_RESIDUAL, 1'($urandom), 14'($urandom), res,
              blpd_pkg::luma_t'($urandom));
  endtask

  task automatic send_random_block();
    logic        big;
    int unsigned pixels;
    big = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 4) == 0) send_frame_start(pick_residual());
    send_header(big, big ? blpd_pkg::OPC_LARGE : blpd_pkg::OPC_SMALL,
                blpd_pkg::luma_t'($urandom), blpd_pkg::luma_t'($urandom));
    pixels = big ? 16 : 4;
    // some blocks are cut short and then abandoned by the next header or frame start
    if ($urandom_range(0, 9) == 0) pixels = $urandom_range(0, pixels - 1);
    repeat (pixels) send_residual(pick_residual());
  endtask

  task automatic send_bad_header();
    logic       big;
    logic [1:0] opc;
    big = 1'($urandom);
    do opc = 2'($urandom);
    while (opc == (big ? blpd_pkg::OPC_LARGE : blpd_pkg::OPC_SMALL));
    send_header(big, opc, blpd_pkg::luma_t'($urandom), blpd_pkg::luma_t'($urandom));
  endtask

  // Receiver: ready pattern switches between a few stall styles.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      pixel_board.check_pixel('{luma_o, chroma_u_o, chroma_v_o, pixel_row_o,
                                pixel_column_o, block_done_o, opcode_error_o});
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    stall_phase = (stall_phase == 9) ? 0 : stall_phase + 1;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (stall_phase < 3);
    endcase
  end

  // Watchdog: ends the run when no handshake happens for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    pixel_board   = new();
    live_items    = 0;
    burst_left    = pick_burst();
    ready_mode    = 0;
    mode_left     = 0;
    stall_phase   = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    command_i     <= blpd_pkg::CMD_FRAME_START;
    block_large_i <= 1'b0;
    header_word_i <= '0;
    residual_i    <= '0;
    start_luma_i  <= '0;
    out_ready_i   <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // residual with no open block is dropped
    send_residual('1);
    send_frame_start('1);
    // full 4x4 block, extreme chroma and residuals
    send_header(1'b1, blpd_pkg::OPC_LARGE, '1, '1);
    send_residual('1);
    send_residual('1);
    send_residual('0);
    send_residual(6'd1);
    send_residual('0);
    send_residual('1);
    send_residual(6'd32);
    send_residual('1);
    send_residual(6'd63);
    send_residual('0);
    send_residual(6'd21);
    send_residual(6'd42);
    send_residual('1);
    send_residual('0);
    send_residual('1);
    send_residual('0);
    // 2x2 block cut short by a bad header, which also closes it
    send_header(1'b0, blpd_pkg::OPC_SMALL, '0, '0);
    send_residual(6'd17);
    send_residual('1);
    send_header(1'b0, 2'd3, '1, '0);
    send_residual(6'd5);
    send_frame_start('0);
    send_item(blpd_pkg::CMD_UNUSED, 1'b1, '1, '1, '1);

    while (live_items < ItemTarget) begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  send_random_block();
        [70:79]: send_bad_header();
        [80:87]: send_frame_start(pick_residual());
        [88:93]: send_residual(pick_residual());
        default: send_item(blpd_pkg::CMD_UNUSED, 1'($urandom), 14'($urandom),
                           blpd_pkg::luma_t'($urandom), blpd_pkg::luma_t'($urandom));
      endcase
    end
    in_valid_i <= 1'b0;

    while (pixel_board.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pixel_board.error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
